### hw/rtl/rte_pkg.sv
// rte_pkg: sizes, node record type, register indexes and controller states
// for the tree extend block.
// No dependencies; imported by rrt_tree_extend.
package rte_pkg;

	// Tree store size and derived widths
	localparam int MAX_NODES = 1024;
	localparam int IDX_W     = $clog2(MAX_NODES);
	localparam int CNT_W     = $clog2(MAX_NODES + 1);

	// Field widths fixed by the interface
	localparam int COORD_W = 16;
	localparam int ID_W    = 10;
	localparam int CFG_W   = 16;
	localparam int REG_W   = 3;
	localparam int SIN_W   = 3 * COORD_W;
	localparam int MOUT_W  = 72;
	localparam int MUSER_W = 3;

	typedef logic [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t theta;
		coord_t y;
		coord_t x;
	} pose_t;

	typedef struct packed {
		logic [ID_W-1:0] parent;
		pose_t           pose;
	} node_rec_t;

	// Configuration register indexes
	typedef enum logic [REG_W-1:0] {
		REG_START_X     = 3'd0,
		REG_START_Y     = 3'd1,
		REG_START_THETA = 3'd2,
		REG_GOAL_X      = 3'd3,
		REG_GOAL_Y      = 3'd4,
		REG_GOAL_THR    = 3'd5,
		REG_FRAC_DIST   = 3'd6,
		REG_FRAC_THETA  = 3'd7
	} rte_reg_e;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_STEP_DIFF,
		ST_STEP_MUL,
		ST_STEP_ADD,
		ST_GOAL_DIFF,
		ST_GOAL_SQ,
		ST_DONE
	} rte_state_e;

endpackage

### hw/rtl/rrt_tree_extend.sv
// rrt_tree_extend: nearest-node search over the tree store, fractional step
// toward the sample, insert of the new node (unless the tree is full) and goal test.
// Depends on rte_pkg.
//
// Channel | Dir | Handshake          | Payload
// s       | in  | s_tvalid/s_tready  | s_tdata: sample_x, sample_y, sample_theta
// m       | out | m_tvalid/m_tready  | m_tdata: node ids and new pose; m_tuser: flags
// cfg     | in  | cfg_we             | cfg_index, cfg_data
//
// For a request the scan reads one stored node per cycle from the node memory,
// then the distance pipe (s1, s2, s3) drains, then the controller steps from
// STEP_DIFF to GOAL_SQ and inserts in DONE once the output register is free.
// A full tree goes from idle straight to the done state, without a scan.
// The node memory needs no clearing after reset: node 0 comes from the start
// registers, and only written entries are read.
// A new request is taken as soon as the controller is idle, while the
// previous result may still sit in the output register.
module rrt_tree_extend (
	input  logic                        clk,
	input  logic                        arst_n,
	// slave request stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [rte_pkg::SIN_W-1:0]   s_tdata,  // sample_x, sample_y, sample_theta
	// master result stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [rte_pkg::MOUT_W-1:0]  m_tdata,  // new_node_id, parent node, new_x,
	                                              // new_y, new_theta, zero pad
	output logic [rte_pkg::MUSER_W-1:0] m_tuser,  // goal_hit, ever_reached, tree_full
	// configuration writes
	input  logic                        cfg_we,
	input  logic [rte_pkg::REG_W-1:0]   cfg_index,
	input  logic [rte_pkg::CFG_W-1:0]   cfg_data
);
	import rte_pkg::*;

	// Configuration registers
	coord_t start_x_q, start_y_q, start_theta_q;
	coord_t goal_x_q, goal_y_q, goal_thr_q;
	logic [CFG_W-1:0] frac_dist_q, frac_theta_q;

	// Controller
	rte_state_e state_q, state_d;
	logic       s_accept;
	logic       out_load;
	logic       scan_done;

	// Request and tree bookkeeping
	pose_t            smp_q;
	logic             full_q;
	logic [CNT_W-1:0] node_count_q;
	logic             reached_q;

	// Node memory
	node_rec_t mem [MAX_NODES];
	node_rec_t rd_rec_q;
	node_rec_t wr_rec;
	logic      mem_we;

	// Scan issue and distance pipe
	logic             iss_active_q;
	logic [IDX_W-1:0] iss_idx_q;
	logic             s1_valid_q, s2_valid_q, s3_valid_q;
	logic [IDX_W-1:0] s1_idx_q, s2_idx_q, s3_idx_q;
	pose_t            s1_pose, s2_pose_s2, s3_pose_s3;
	coord_t           s2_dx_s2, s2_dy_s2;
	logic [2*COORD_W-1:0] s3_dx2_s3, s3_dy2_s3;
	logic [2*COORD_W:0]   s3_dist;

	// Best node so far
	logic [2*COORD_W:0] best_d_q;
	logic [IDX_W-1:0]   best_id_q;
	pose_t              best_pose_q;

	// Step toward the sample, lanes x, y, theta
	logic [2:0]           stp_neg_q;
	coord_t               stp_mag_q  [3];
	logic [2*COORD_W-1:0] stp_prod_q [3];
	coord_t               stp_from   [3];
	coord_t               stp_to     [3];
	logic [CFG_W-1:0]     stp_frac   [3];
	coord_t               stp_new    [3];
	pose_t                new_pose_q;

	// Goal test
	coord_t               gdx_q, gdy_q;
	logic [2*COORD_W-1:0] gdx2_q, gdy2_q, thr2_q;
	logic                 goal_hit;

	// Output register
	logic                  m_tvalid_q;
	logic [MOUT_W-1:0]     m_tdata_q;
	logic [MUSER_W-1:0]    m_tuser_q;

	function automatic coord_t abs_diff(input coord_t a, input coord_t b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic logic full_q_next();
		return node_count_q >= CNT_W'(MAX_NODES);
	endfunction

	assign s_accept = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q     <= '0;
			start_y_q     <= '0;
			start_theta_q <= '0;
			goal_x_q      <= '0;
			goal_y_q      <= '0;
			goal_thr_q    <= COORD_W'(16);
			frac_dist_q   <= CFG_W'(6554);
			frac_theta_q  <= CFG_W'(6554);
		end else if (cfg_we) begin
			unique case (rte_reg_e'(cfg_index))
				REG_START_X:     start_x_q     <= cfg_data;
				REG_START_Y:     start_y_q     <= cfg_data;
				REG_START_THETA: start_theta_q <= cfg_data;
				REG_GOAL_X:      goal_x_q      <= cfg_data;
				REG_GOAL_Y:      goal_y_q      <= cfg_data;
				REG_GOAL_THR:    goal_thr_q    <= cfg_data;
				REG_FRAC_DIST:   frac_dist_q   <= cfg_data;
				REG_FRAC_THETA:  frac_theta_q  <= cfg_data;
			endcase
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (s_accept) state_d = full_q_next() ? ST_DONE : ST_SCAN;
			ST_SCAN:      if (scan_done) state_d = ST_STEP_DIFF;
			ST_STEP_DIFF: state_d = ST_STEP_MUL;
			ST_STEP_MUL:  state_d = ST_STEP_ADD;
			ST_STEP_ADD:  state_d = ST_GOAL_DIFF;
			ST_GOAL_DIFF: state_d = ST_GOAL_SQ;
			ST_GOAL_SQ:   state_d = ST_DONE;
			ST_DONE:      if (out_load) state_d = ST_IDLE;
		endcase
	end

	// Controller outputs
	always_comb begin
		s_tready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_DONE: out_load = !m_tvalid_q || m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// Request capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (s_accept) begin
			full_q <= full_q_next();
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) smp_q <= s_tdata;
	end

	// Node memory: one write at insert, one read per scan cycle
	assign mem_we      = out_load && !full_q;
	assign wr_rec.pose   = new_pose_q;
	assign wr_rec.parent = ID_W'(best_id_q);

	always_ff @(posedge clk) begin
		if (mem_we) mem[node_count_q[IDX_W-1:0]] <= wr_rec;
		rd_rec_q <= mem[iss_idx_q];
	end

	// Scan address issue: indexes 0 .. node_count-1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_active_q <= 1'b0;
			iss_idx_q    <= '0;
		end else if (s_accept) begin
			iss_active_q <= !full_q_next();
			iss_idx_q    <= '0;
		end else if (iss_active_q) begin
			if (CNT_W'(iss_idx_q) + CNT_W'(1) == node_count_q) iss_active_q <= 1'b0;
			else                                               iss_idx_q <= iss_idx_q + 1'b1;
		end
	end

	// Root pose is live from the start registers
	assign s1_pose = (s1_idx_q == '0) ? pose_t'{start_theta_q, start_y_q, start_x_q}
	                                  : rd_rec_q.pose;
	assign s3_dist = {1'b0, s3_dx2_s3} + {1'b0, s3_dy2_s3};
	assign scan_done = !iss_active_q && !s1_valid_q && !s2_valid_q && !s3_valid_q;

	// Distance pipe valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
			s3_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= iss_active_q;
			s2_valid_q <= s1_valid_q;
			s3_valid_q <= s2_valid_q;
		end
	end

	// Distance pipe payload: abs diffs, then squares
	always_ff @(posedge clk) begin
		s1_idx_q   <= iss_idx_q;
		s2_idx_q   <= s1_idx_q;
		s2_pose_s2 <= s1_pose;
		s2_dx_s2   <= abs_diff(s1_pose.x, smp_q.x);
		s2_dy_s2   <= abs_diff(s1_pose.y, smp_q.y);
		s3_idx_q   <= s2_idx_q;
		s3_pose_s3 <= s2_pose_s2;
		s3_dx2_s3  <= s2_dx_s2 * s2_dx_s2;
		s3_dy2_s3  <= s2_dy_s2 * s2_dy_s2;
	end

	// Running minimum; strict compare keeps the lowest index on ties
	always_ff @(posedge clk) begin
		if (s3_valid_q && (s3_idx_q == '0 || s3_dist < best_d_q)) begin
			best_d_q    <= s3_dist;
			best_id_q   <= s3_idx_q;
			best_pose_q <= s3_pose_s3;
		end
	end

	// Step lanes
	assign stp_from[0] = best_pose_q.x;
	assign stp_from[1] = best_pose_q.y;
	assign stp_from[2] = best_pose_q.theta;
	assign stp_to[0]   = smp_q.x;
	assign stp_to[1]   = smp_q.y;
	assign stp_to[2]   = smp_q.theta;
	assign stp_frac[0] = frac_dist_q;
	assign stp_frac[1] = frac_dist_q;
	assign stp_frac[2] = frac_theta_q;

	// Floor of a negative step rounds the magnitude up
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (stp_neg_q[l])
				stp_new[l] = stp_from[l] - COORD_W'((stp_prod_q[l] + 32'hFFFF) >> 16);
			else
				stp_new[l] = stp_from[l] + stp_prod_q[l][31:16];
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			if (state_q == ST_STEP_DIFF) begin
				stp_neg_q[l] <= stp_to[l] < stp_from[l];
				stp_mag_q[l] <= abs_diff(stp_to[l], stp_from[l]);
			end
			if (state_q == ST_STEP_MUL) stp_prod_q[l] <= stp_mag_q[l] * stp_frac[l];
		end
		if (state_q == ST_STEP_ADD) new_pose_q <= pose_t'{stp_new[2], stp_new[1], stp_new[0]};
	end

	// Goal distance, squared against threshold squared
	always_ff @(posedge clk) begin
		if (state_q == ST_GOAL_DIFF) begin
			gdx_q <= abs_diff(new_pose_q.x, goal_x_q);
			gdy_q <= abs_diff(new_pose_q.y, goal_y_q);
		end
		if (state_q == ST_GOAL_SQ) begin
			gdx2_q <= gdx_q * gdx_q;
			gdy2_q <= gdy_q * gdy_q;
			thr2_q <= goal_thr_q * goal_thr_q;
		end
	end

	assign goal_hit = ({1'b0, gdx2_q} + {1'b0, gdy2_q}) < {1'b0, thr2_q};

	// Insert and sticky reached flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CNT_W'(1);
			reached_q    <= 1'b0;
		end else if (mem_we) begin
			node_count_q <= node_count_q + CNT_W'(1);
			reached_q    <= reached_q || goal_hit;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (full_q) begin
				m_tdata_q <= '0;
				m_tuser_q <= {1'b1, reached_q, 1'b0};
			end else begin
				m_tdata_q <= MOUT_W'({new_pose_q.theta, new_pose_q.y, new_pose_q.x,
				                      ID_W'(best_id_q), ID_W'(node_count_q)});
				m_tuser_q <= {1'b0, reached_q || goal_hit, goal_hit};
			end
		end
	end

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		node_count_q <= CNT_W'(MAX_NODES))
		else $error("node count beyond store size");

	a_scan_in_tree: assert property (@(posedge clk) disable iff (!arst_n)
		iss_active_q |-> CNT_W'(iss_idx_q) < node_count_q)
		else $error("scan reads past the last node");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> node_count_q == $past(node_count_q) + CNT_W'(1))
		else $error("insert did not advance node count");

	a_load_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_DONE))
		else $error("result presented outside the done state");

	a_reached_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		reached_q |=> reached_q)
		else $error("reached flag cleared");

endmodule
